// File: hw/rtl/vpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vpa_pkg;
  localparam int unsigned MaxSegmentsDefault = 32;
  localparam int unsigned AddrBitsDefault = 16;
  localparam int unsigned SizeW = 16;
  localparam int unsigned JobW = 8;
  localparam int unsigned StatusW = 3;
  localparam logic [SizeW-1:0] MemSizeReset = 16'd1024;

  localparam logic [StatusW-1:0] StOk = 3'd0;
  localparam logic [StatusW-1:0] StNoFit = 3'd1;
  localparam logic [StatusW-1:0] StBad = 3'd2;
  localparam logic [StatusW-1:0] StFull = 3'd3;
  localparam logic [StatusW-1:0] StNotFound = 3'd4;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree = 1'b1;

  localparam logic [0:0] RegMemSize = 1'b0;
  localparam logic [0:0] RegPolicy = 1'b1;
endpackage
`default_nettype wire

// File: hw/rtl/vpa_table.sv
`timescale 1ns / 1ps
`default_nettype none
// segment table: one entry read and one written per cycle, read data registered
module vpa_table #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrBits = 16,
  parameter int unsigned IdxW = 5
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [IdxW-1:0]     waddr_i,
  input  wire logic [AddrBits-1:0] wstart_i,
  input  wire logic [vpa_pkg::SizeW-1:0] wlen_i,
  input  wire logic [vpa_pkg::JobW-1:0]  wowner_i,
  input  wire logic                wbusy_i,
  input  wire logic [IdxW-1:0]     raddr_i,
  output logic [AddrBits-1:0]      rstart_o,
  output logic [vpa_pkg::SizeW-1:0] rlen_o,
  output logic [vpa_pkg::JobW-1:0] rowner_o,
  output logic                     rbusy_o
);
  import vpa_pkg::*;
  logic [AddrBits+SizeW+JobW:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wstart_i, wlen_i, wowner_i, wbusy_i};
    end
    {rstart_o, rlen_o, rowner_o, rbusy_o} <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: hw/rtl/variable_partition_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// a transaction scans the table entry by entry (read, then compare), then, for a split or a merge,
// shifts entries one at a time to insert or remove a segment
// throughput: one transaction at a time; the table's one read and one write per cycle set the pace
// reset: asynchronous active low; table holds one free segment of 1024 units,
// built in the first cycle after reset while in_stall_o is held high
// memory_size write rebuilds the table at once if idle (entry 0 written, count set to one)
module variable_partition_allocator_top #(
  parameter int unsigned MAX_SEGMENTS = vpa_pkg::MaxSegmentsDefault,
  parameter int unsigned ADDR_BITS = vpa_pkg::AddrBitsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [vpa_pkg::SizeW-1:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire logic operation_i,
  input  wire logic [vpa_pkg::JobW-1:0] job_id_i,
  input  wire logic [vpa_pkg::SizeW-1:0] request_size_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic [vpa_pkg::StatusW-1:0] status_o,
  output logic [vpa_pkg::SizeW-1:0] granted_address_o
);
  import vpa_pkg::*;
  localparam int unsigned IdxW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SEGMENTS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_DECIDE, S_SPL_RD, S_SPL_WR, S_SPL_FIN,
    S_FR_NX, S_FR_NXW, S_FR_RD, S_FR_PV, S_FR_PVW, S_RM_RD, S_RM_WR, S_DONE
  } state_e;

  state_e state_q;
  logic [SizeW-1:0] mem_size_q;
  logic policy_q;
  logic [CntW-1:0] count_q;
  logic op_q;
  logic [JobW-1:0] job_q;
  logic [SizeW-1:0] size_q;
  logic [CntW-1:0] k_q;          // scan / shift position
  logic found_q;
  logic [IdxW-1:0] pick_q;
  logic [SizeW-1:0] best_q;      // remainder of best candidate
  logic [ADDR_BITS-1:0] pstart_q;
  logic [SizeW-1:0] plen_q;
  logic [IdxW-1:0] keep_q;       // entry that absorbs
  logic [SizeW-1:0] klen_q;
  logic [ADDR_BITS-1:0] kstart_q;
  logic [StatusW-1:0] status_q;
  logic [SizeW-1:0] addr_q;

  // memory ports
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [ADDR_BITS-1:0] wstart, rstart;
  logic [SizeW-1:0] wlen, rlen;
  logic [JobW-1:0] wowner, rowner;
  logic wbusy, rbusy;

  vpa_table #(.Depth(MAX_SEGMENTS), .AddrBits(ADDR_BITS), .IdxW(IdxW)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wstart_i(wstart), .wlen_i(wlen),
    .wowner_i(wowner), .wbusy_i(wbusy), .raddr_i(raddr), .rstart_o(rstart),
    .rlen_o(rlen), .rowner_o(rowner), .rbusy_o(rbusy)
  );

  // shared compare / subtract unit
  logic [SizeW-1:0] rem;
  logic fits, better;
  assign rem = rlen - size_q;
  assign fits = !rbusy && (rlen >= size_q);
  assign better = !found_q || (rem < best_q);

  logic cfg_rebuild;
  assign cfg_rebuild = cfg_we_i && (cfg_index_i == RegMemSize);

  // write port and read address selection
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wstart = '0;
    wlen = '0;
    wowner = '0;
    wbusy = 1'b0;
    raddr = k_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        // entry 0 built after reset or on a memory_size write
        we = cfg_rebuild || (count_q == '0);
        wlen = cfg_rebuild ? cfg_data_i : mem_size_q;
      end
      S_DECIDE: begin
        // busy head written in place, for an exact fit or ahead of a split
        we = (op_q == OpAlloc) && found_q && ((plen_q == size_q) || (count_q < CntMax));
        waddr = pick_q;
        wstart = pstart_q;
        wlen = size_q;
        wowner = job_q;
        wbusy = 1'b1;
      end
      S_SPL_WR: begin
        we = 1'b1;
        waddr = IdxW'(k_q);
        wstart = rstart;
        wlen = rlen;
        wowner = rowner;
        wbusy = rbusy;
        raddr = IdxW'(k_q - 2'd2);
      end
      S_SPL_RD: raddr = IdxW'(k_q - 1'b1);
      S_SPL_FIN: begin
        // free remainder above the busy head
        we = 1'b1;
        waddr = IdxW'(pick_q + 1'b1);
        wstart = ADDR_BITS'(pstart_q + ADDR_BITS'(size_q));
        wlen = plen_q - size_q;
      end
      S_FR_NX: begin
        we = 1'b1;
        waddr = pick_q;
        wstart = pstart_q;
        wlen = plen_q;
        raddr = IdxW'(pick_q + 1'b1);
      end
      S_FR_NXW: begin
        we = 1'b1;
        waddr = keep_q;
        wstart = kstart_q;
        wlen = klen_q;
        raddr = IdxW'(pick_q - 1'b1);
      end
      S_FR_RD: begin
        // merged length stored, previous neighbor read
        we = 1'b1;
        waddr = keep_q;
        wstart = kstart_q;
        wlen = klen_q;
        raddr = IdxW'(pick_q - 1'b1);
      end
      S_FR_PVW: begin
        we = 1'b1;
        waddr = keep_q;
        wstart = kstart_q;
        wlen = klen_q;
      end
      S_RM_RD: raddr = IdxW'(k_q + 1'b1);
      S_RM_WR: begin
        we = 1'b1;
        waddr = IdxW'(k_q);
        wstart = rstart;
        wlen = rlen;
        wowner = rowner;
        wbusy = rbusy;
        raddr = IdxW'(k_q + 2'd2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mem_size_q <= MemSizeReset;
      policy_q <= 1'b0;
      count_q <= '0;   // zero marks table not yet built after reset
      status_q <= StOk;
      addr_q <= '0;
      op_q <= OpAlloc;
      job_q <= '0;
      size_q <= '0;
      k_q <= '0;
      found_q <= 1'b0;
      pick_q <= '0;
      best_q <= '0;
      pstart_q <= '0;
      plen_q <= '0;
      keep_q <= '0;
      klen_q <= '0;
      kstart_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i && cfg_index_i == RegPolicy) policy_q <= cfg_data_i[0];
          if (cfg_rebuild) begin
            mem_size_q <= cfg_data_i;
            count_q <= CntW'(1);
          end else if (count_q == '0) begin
            count_q <= CntW'(1);   // entry 0 written from mem_size_q this cycle
          end
          if (in_valid_i && !in_stall_o) begin
            op_q <= operation_i;
            job_q <= job_id_i;
            size_q <= request_size_i;
            k_q <= '0;
            found_q <= 1'b0;
            addr_q <= '0;
            if (job_id_i == '0 || (operation_i == OpAlloc && request_size_i == '0)) begin
              status_q <= StBad;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: state_q <= S_SCAN;
        S_SCAN: begin
          if (op_q == OpAlloc ? (fits && better) : (rbusy && rowner == job_q)) begin
            found_q <= 1'b1;
            pick_q <= IdxW'(k_q);
            best_q <= rem;
            pstart_q <= rstart;
            plen_q <= rlen;
          end
          if ((op_q == OpAlloc && fits && !policy_q) ||
              (op_q == OpFree && rbusy && rowner == job_q) ||
              (k_q + 1'b1 == count_q)) begin
            state_q <= S_DECIDE;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_DECIDE: begin
          if (!found_q) begin
            status_q <= (op_q == OpAlloc) ? StNoFit : StNotFound;
            state_q <= S_DONE;
          end else if (op_q == OpFree) begin
            klen_q <= plen_q;
            kstart_q <= pstart_q;
            keep_q <= pick_q;
            status_q <= StOk;
            state_q <= S_FR_NX;
          end else if (plen_q == size_q) begin
            status_q <= StOk;
            addr_q <= SizeW'(pstart_q);
            state_q <= S_DONE;
          end else if (count_q >= CntMax) begin
            status_q <= StFull;
            state_q <= S_DONE;
          end else begin
            status_q <= StOk;
            addr_q <= SizeW'(pstart_q);
            k_q <= count_q;
            state_q <= (count_q == CntW'(pick_q) + 1'b1) ? S_SPL_FIN : S_SPL_RD;
          end
        end
        // shift entries pick+1..count-1 up by one, top first
        S_SPL_RD: state_q <= S_SPL_WR;
        S_SPL_WR: begin
          k_q <= k_q - 1'b1;
          if (k_q - 1'b1 == CntW'(pick_q) + 1'b1) state_q <= S_SPL_FIN;
        end
        S_SPL_FIN: begin
          count_q <= count_q + 1'b1;
          state_q <= S_DONE;
        end
        // free: entry released (written in S_FR_NX), next read issued
        S_FR_NX: begin
          state_q <= S_FR_NXW;
        end
        S_FR_NXW: begin
          // rdata: entry pick+1
          if (CntW'(pick_q) + 1'b1 < count_q && !rbusy) begin
            klen_q <= klen_q + rlen;
            k_q <= CntW'(pick_q) + 1'b1;
            state_q <= (CntW'(pick_q) + 2'd2 < count_q) ? S_RM_RD : S_FR_RD;
            if (!(CntW'(pick_q) + 2'd2 < count_q)) count_q <= count_q - 1'b1;
          end else begin
            state_q <= S_FR_PV;
          end
          op_q <= OpFree;
        end
        S_FR_RD: state_q <= S_FR_PV;
        S_FR_PV: begin
          // rdata: entry pick-1
          if (pick_q != '0 && !rbusy) begin
            klen_q <= rlen + klen_q;
            kstart_q <= rstart;
            keep_q <= IdxW'(pick_q - 1'b1);
            k_q <= CntW'(pick_q);
            op_q <= OpAlloc;   // marks second merge pending
            state_q <= S_FR_PVW;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_FR_PVW: begin
          if (k_q + 1'b1 < count_q) begin
            state_q <= S_RM_RD;
          end else begin
            count_q <= count_q - 1'b1;
            state_q <= S_DONE;
          end
        end
        // remove entry k: pull entries down
        S_RM_RD: state_q <= S_RM_WR;
        S_RM_WR: begin
          if (k_q + 2'd2 < count_q) begin
            k_q <= k_q + 1'b1;
          end else begin
            count_q <= count_q - 1'b1;
            // after the next-merge, store the merged length and check previous neighbor
            if (op_q == OpFree) begin
              state_q <= S_FR_RD;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE) || (count_q == '0);
  assign out_valid_o = (state_q == S_DONE);
  assign status_o = status_q;
  assign granted_address_o = addr_q;
endmodule
`default_nettype wire

// File: hw/rtl/vpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module vpa_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [vpa_pkg::StatusW-1:0] status_o,
  input wire logic [vpa_pkg::SizeW-1:0] granted_address_o
);
  import vpa_pkg::*;
  // no new transaction while a result is pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during result");
  // status stays in its code range
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StOk || status_o == StNoFit || status_o == StBad ||
                     status_o == StFull || status_o == StNotFound))
    else $error("bad status");
  // only a success carries an address
  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> granted_address_o == '0)
    else $error("address on failure");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
endmodule
bind variable_partition_allocator_top vpa_checker u_vpa_checker (.*);
`default_nettype wire

// File: dv/tb_variable_partition_allocator_top.sv
`timescale 1ns / 1ps
module tb_variable_partition_allocator_top;
  import vpa_pkg::*;

  localparam int NSEG = 32;
  localparam int CYCLE_LIMIT = 900000;

  // one request transaction as the driver presents it
  typedef struct packed {
    logic op;
    logic [JobW-1:0] job;
    logic [SizeW-1:0] size;
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SizeW-1:0] addr;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = RegMemSize;
  logic [SizeW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = OpAlloc;
  logic [JobW-1:0] job_id_i = '0;
  logic [SizeW-1:0] request_size_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [SizeW-1:0] granted_address_o;

  variable_partition_allocator_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .job_id_i, .request_size_i,
    .out_valid_o, .out_stall_i, .status_o, .granted_address_o
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the segment table, kept in address order
  logic [SizeW-1:0] seg_base [NSEG];
  logic [SizeW-1:0] seg_len [NSEG];
  logic [JobW-1:0] seg_job [NSEG];
  logic seg_used [NSEG];
  int seg_total;
  logic [SizeW-1:0] mem_units;
  logic best_fit;

  request_t pending_requests[$];
  grant_t expected_grants[$];
  int errors = 0;
  int cycles = 0;
  bit idle_gaps = 1'b1;   // off during a burst phase with no idling

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void rebuild_segments();
    for (int k = 0; k < NSEG; k++) begin
      seg_base[k] = '0; seg_len[k] = '0; seg_job[k] = '0; seg_used[k] = 1'b0;
    end
    seg_len[0] = mem_units;
    seg_total = 1;
  endfunction

  function automatic void copy_segment(int to, int from);
    seg_base[to] = seg_base[from];
    seg_len[to] = seg_len[from];
    seg_job[to] = seg_job[from];
    seg_used[to] = seg_used[from];
  endfunction

  function automatic void drop_segment(int idx);
    for (int k = idx; k + 1 < seg_total; k++) copy_segment(k, k + 1);
    seg_total--;
  endfunction

  // compute the grant for one request and update the shadow table
  function automatic grant_t allocate_or_release(request_t r);
    grant_t g;
    int pick;
    logic [SizeW-1:0] slack;
    pick = -1;
    slack = '0;
    g.status = StOk;
    g.addr = '0;
    if (r.op == OpAlloc) begin
      if (r.job == 0 || r.size == 0) begin
        g.status = StBad;
        return g;
      end
      for (int k = 0; k < seg_total; k++) begin
        if (seg_used[k] || seg_len[k] < r.size) continue;
        if (!best_fit) begin
          pick = k;
          break;
        end
        if (pick < 0 || seg_len[k] - r.size < slack) begin
          pick = k;
          slack = seg_len[k] - r.size;
        end
      end
      if (pick < 0) begin
        g.status = StNoFit;
      end else if (seg_len[pick] == r.size) begin
        seg_used[pick] = 1'b1;
        seg_job[pick] = r.job;
        g.addr = seg_base[pick];
      end else if (seg_total >= NSEG) begin
        g.status = StFull;
      end else begin
        for (int k = seg_total; k > pick; k--) copy_segment(k, k - 1);
        seg_total++;
        seg_len[pick] = r.size;
        seg_used[pick] = 1'b1;
        seg_job[pick] = r.job;
        seg_base[pick + 1] = seg_base[pick] + r.size;
        seg_len[pick + 1] = seg_len[pick + 1] - r.size;
        seg_used[pick + 1] = 1'b0;
        seg_job[pick + 1] = '0;
        g.addr = seg_base[pick];
      end
    end else begin
      if (r.job == 0) begin
        g.status = StBad;
        return g;
      end
      for (int k = 0; k < seg_total; k++) begin
        if (seg_used[k] && seg_job[k] == r.job) begin
          pick = k;
          break;
        end
      end
      if (pick < 0) begin
        g.status = StNotFound;
        return g;
      end
      seg_used[pick] = 1'b0;
      seg_job[pick] = '0;
      // merge with the free neighbor above, then below
      if (pick + 1 < seg_total && !seg_used[pick + 1]) begin
        seg_len[pick] = seg_len[pick] + seg_len[pick + 1];
        drop_segment(pick + 1);
      end
      if (pick > 0 && !seg_used[pick - 1]) begin
        seg_len[pick - 1] = seg_len[pick - 1] + seg_len[pick];
        drop_segment(pick);
      end
    end
    return g;
  endfunction

  // driver: pops pending requests, waits a random gap, holds until accepted
  int drive_gap = 0;
  bit in_taken = 1'b0;   // set at the rising edge that accepts a transaction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) in_taken = 1'b1;
  end

  always @(negedge clk_i) begin
    bit slot_free;
    request_t r;
    slot_free = !in_valid_i || in_taken;
    in_taken = 1'b0;
    if (rst_ni && slot_free) begin
      if (drive_gap > 0) begin
        drive_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        r = pending_requests.pop_front();
        operation_i <= r.op;
        job_id_i <= r.job;
        request_size_i <= r.size;
        in_valid_i <= 1'b1;
        expected_grants.push_back(allocate_or_release(r));
        drive_gap = idle_gaps ? $urandom_range(0, 12) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall: random holds per transaction
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          grant_t e;
          e = expected_grants.pop_front();
          if (status_o !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, e.status));
          if (granted_address_o !== e.addr)
            report_mismatch($sformatf("address %0d, expected %0d",
                                      granted_address_o, e.addr));
        end
        stall_left = idle_gaps ? $urandom_range(0, 12) : 0;
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("variable_partition_allocator_top regression: fail");
        $finish;
      end
    end
  end

  function automatic request_t make_req(logic op, int job, int size);
    request_t r;
    r.op = op;
    r.job = job[JobW-1:0];
    r.size = size[SizeW-1:0];
    return r;
  endfunction

  // wait until every queued transaction has produced its result
  task automatic drain();
    while (pending_requests.size() > 0 || expected_grants.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (2 * NSEG + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[SizeW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegMemSize) begin
      mem_units = value[SizeW-1:0];
      rebuild_segments();
    end else begin
      best_fit = value[0];
    end
  endtask

  // mostly well-formed traffic over a small job pool so frees find owners
  task automatic random_phase(int count, int max_size);
    for (int i = 0; i < count; i++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
        pending_requests.push_back(make_req(OpAlloc, $urandom_range(1, 12),
                                            $urandom_range(1, max_size)));
      else if (pick < 90)
        pending_requests.push_back(make_req(OpFree, $urandom_range(1, 12),
                                            $urandom()));
      else
        // noise: any id, any size, either operation
        pending_requests.push_back(make_req(1'($urandom_range(0, 1)),
                                            $urandom_range(0, 255), $urandom()));
    end
  endtask

  initial begin
    mem_units = MemSizeReset;
    best_fit = 1'b0;
    rebuild_segments();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset table, special cases and field extremes
    pending_requests.push_back(make_req(OpAlloc, 0, 10));        // id zero
    pending_requests.push_back(make_req(OpAlloc, 5, 0));         // size zero
    pending_requests.push_back(make_req(OpFree, 0, 0));          // free id zero
    pending_requests.push_back(make_req(OpFree, 9, 65535));      // id owns nothing
    pending_requests.push_back(make_req(OpAlloc, 255, 65535));   // no fit
    pending_requests.push_back(make_req(OpAlloc, 1, 100));
    pending_requests.push_back(make_req(OpAlloc, 2, 200));
    pending_requests.push_back(make_req(OpAlloc, 1, 50));        // duplicate id
    pending_requests.push_back(make_req(OpAlloc, 3, 300));
    pending_requests.push_back(make_req(OpFree, 1, 0));          // lowest of the dups
    pending_requests.push_back(make_req(OpFree, 3, 0));          // merge with tail
    pending_requests.push_back(make_req(OpFree, 2, 0));          // merge with the free segment below
    pending_requests.push_back(make_req(OpFree, 1, 0));
    pending_requests.push_back(make_req(OpAlloc, 170, 1024));    // exact fit, whole
    pending_requests.push_back(make_req(OpFree, 170, 0));
    drain();

    // table full: 31 one-unit splits, then one more split refused
    write_reg(RegMemSize, 64);
    for (int i = 0; i < 32; i++)
      pending_requests.push_back(make_req(OpAlloc, i + 1, 1));
    pending_requests.push_back(make_req(OpAlloc, 99, 33));       // exact fit of rest
    drain();

    // best fit with holes of different sizes
    write_reg(RegMemSize, 65535);
    write_reg(RegPolicy, 1);
    pending_requests.push_back(make_req(OpAlloc, 1, 500));
    pending_requests.push_back(make_req(OpAlloc, 2, 10));
    pending_requests.push_back(make_req(OpAlloc, 3, 100));
    pending_requests.push_back(make_req(OpAlloc, 4, 10));
    pending_requests.push_back(make_req(OpFree, 1, 0));
    pending_requests.push_back(make_req(OpFree, 3, 0));
    pending_requests.push_back(make_req(OpAlloc, 5, 90));
    drain();

    write_reg(RegMemSize, 0);                                    // empty memory
    pending_requests.push_back(make_req(OpAlloc, 1, 1));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      int sz;
      case (ph % 4)
        0: sz = 1;
        1: sz = 65535;
        2: sz = $urandom_range(16, 300);
        default: sz = $urandom_range(1, 65535);
      endcase
      write_reg(RegMemSize, sz);
      write_reg(RegPolicy, ph % 2);
      idle_gaps = (ph != 5);
      random_phase(100, (sz < 40) ? 40 : sz / 8);
      if (ph == 7) random_phase(1, 65535);
      drain();
    end

    if (errors == 0) begin
      $display("variable_partition_allocator_top regression: pass");
    end else begin
      $display("variable_partition_allocator_top regression: fail");
    end
    $finish;
  end
endmodule
